// ===== rtl/core/wsst_pkg.sv =====
// Package for the weighted selection sum tree: operation codes and the
// front-to-back command type. No dependencies.
package wsst_pkg;
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_ZERO   = 2'd2;
    localparam logic [1:0] OP_SELECT = 2'd3;
    localparam int POS_W    = 11;
    localparam int AMOUNT_W = 32;
    localparam int TARGET_W = 48;
    localparam int TOTAL_W  = 42;

    typedef struct packed {
        logic [1:0]          mode;
        logic [POS_W-1:0]    position;
        logic [AMOUNT_W-1:0] amount;
        logic [TARGET_W-1:0] target;
    } t_cmd;
endpackage

// ===== rtl/core/weighted_select_sum_tree.sv =====
// Top level of the weighted selection sum tree.
// Instantiates wsst_front and wsst_engine; uses wsst_pkg.
//
// Usage: push an item (mode, position, amount, target) while o_full is low.
// Each item yields one result (selected slot, total weight, beyond flag),
// shown while o_empty is low and taken with i_pop.
// An add or zero rewrites the leaf, then each tree node on its update path;
// a select descends the tree from the top; a clear rewrites every slot.
// Each tree level is a read, registered read data, then a decide or write
// step on the tree memory.
// Items run one at a time; the next queued item is taken in the cycle after
// the result is taken.
// Reset: a clear pass sets each slot to one; items wait in the two-entry
// input queue meanwhile.
// A stalled result holds the engine; the queue keeps taking items until full.
module weighted_select_sum_tree #(
    parameter int SLOT_COUNT = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [1:0]    i_mode,
    input  logic [10:0]   i_position,
    input  logic [31:0]   i_amount,
    input  logic [47:0]   i_target,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [10:0]   o_selected_slot,
    output logic [41:0]   o_total_weight,
    output logic          o_beyond_total
);
    localparam int IDX_W = $clog2(SLOT_COUNT + 1);
    wsst_pkg::t_cmd in_cmd, q_cmd;
    logic q_valid, q_take, res_valid;

    assign in_cmd = '{mode: i_mode, position: i_position, amount: i_amount,
        target: i_target};

    wsst_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_cmd(in_cmd),
        .o_valid(q_valid), .o_cmd(q_cmd), .i_take(q_take)
    );

    wsst_engine #(.SLOT_COUNT(SLOT_COUNT), .IDX_W(IDX_W)) u_engine (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_cmd(q_cmd), .o_take(q_take),
        .o_res_valid(res_valid), .i_res_ready(i_pop),
        .o_slot(o_selected_slot), .o_total(o_total_weight),
        .o_beyond(o_beyond_total)
    );
    assign o_empty = !res_valid;
endmodule

// ===== rtl/core/wsst_front.sv =====
// Front stage: accepts items and holds them in a short queue for the engine.
// Depends on wsst_pkg.
module wsst_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  wsst_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    output wsst_pkg::t_cmd  o_cmd,
    input  logic            i_take
);
    wsst_pkg::t_cmd r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd, r_wr;
    logic       wr, rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rd];
    assign wr = i_push && !o_full;
    assign rd = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (wr) r_wr <= ~r_wr;
            if (rd) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

// ===== rtl/core/wsst_engine.sv =====
// Back stage: binary indexed sum tree in a memory, leaf weights in a second
// memory. Depends on wsst_pkg.
module wsst_engine #(
    parameter int SLOT_COUNT = 1024,
    parameter int IDX_W      = 11
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  wsst_pkg::t_cmd                 i_cmd,
    output logic                           o_take,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output logic [wsst_pkg::POS_W-1:0]     o_slot,
    output logic [wsst_pkg::TOTAL_W-1:0]   o_total,
    output logic                           o_beyond
);
    localparam int SW = 64;
    localparam logic [IDX_W-1:0] N = IDX_W'(SLOT_COUNT);
    localparam int TOP = (SLOT_COUNT <= 1) ? 1 : (1 << ($clog2(SLOT_COUNT) - 1));

    localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_LRD = 4'd2,
        S_LWAIT = 4'd3, S_URD = 4'd4, S_UWAIT = 4'd5, S_UWR = 4'd6,
        S_FRD = 4'd7, S_FWAIT = 4'd8, S_FDEC = 4'd9, S_OUT = 4'd10,
        S_C1 = 4'd11;

    logic [SW-1:0] tree [SLOT_COUNT+1];
    logic [31:0]   leaf [SLOT_COUNT+1];

    logic [3:0]       r_st, n_st;
    wsst_pkg::t_cmd   r_cmd;
    logic [IDX_W:0]   r_i, r_cnt;
    logic [IDX_W:0]   r_pos, r_step;
    logic [SW-1:0]    r_want, r_delta, r_tot, r_rd;
    logic [31:0]      r_lrd;
    logic [IDX_W:0]   r_slot;
    logic             r_beyond;

    logic             t_we;
    logic [IDX_W:0]   t_wa, t_ra;
    logic [SW-1:0]    t_wd;
    logic             l_we;
    logic [IDX_W:0]   l_a;
    logic [31:0]      l_wd;
    logic [IDX_W:0]   nxt, lowb;
    logic [IDX_W:0]   node_lo, node_hi, node_ones;
    logic [32:0]      sum33;
    logic [31:0]      newleaf;
    logic [IDX_W:0]   clamp;

    always_ff @(posedge i_clk) begin
        if (t_we) tree[t_wa[IDX_W-1:0]] <= t_wd;
        r_rd <= tree[t_ra[IDX_W-1:0]];
        if (l_we) leaf[l_a[IDX_W-1:0]] <= l_wd;
        r_lrd <= leaf[l_a[IDX_W-1:0]];
    end

    assign lowb = r_i & (~r_i + 1'b1);
    assign nxt  = r_pos + r_step;
    assign clamp = ({1'b0, r_cmd.position} == '0) ? (IDX_W+1)'(1) :
        ({1'b0, r_cmd.position} > {1'b0, N}) ? {1'b0, N} :
        (IDX_W+1)'(r_cmd.position);
    assign sum33 = {1'b0, r_lrd} + {1'b0, r_cmd.amount};
    assign newleaf = (r_cmd.mode == wsst_pkg::OP_ZERO) ? 32'd0 :
        (sum33[32] ? 32'hFFFF_FFFF : sum33[31:0]);

    // node i covers slots i-lowbit(i)+1 .. i; count the ones among them
    assign node_lo   = r_i - lowb;
    assign node_hi   = (r_i <= r_cnt) ? r_i : r_cnt;
    assign node_ones = (node_hi > node_lo) ? node_hi - node_lo : '0;

    assign o_take      = (r_st == S_IDLE) && i_valid;
    assign o_res_valid = (r_st == S_OUT);
    assign o_slot      = r_slot[wsst_pkg::POS_W-1:0];
    assign o_total     = r_tot[wsst_pkg::TOTAL_W-1:0];
    assign o_beyond    = r_beyond;

    // Next state; clear writes each leaf and its tree node directly, one pass.
    always_comb begin
        n_st = r_st;
        t_we = 1'b0; t_wa = r_i; t_wd = '0; t_ra = r_i;
        l_we = 1'b0; l_a = r_i; l_wd = '0;
        case (r_st)
            S_INIT, S_C1: begin
                t_we = (r_i != '0);
                l_we = 1'b1;
                l_wd = (r_i != '0 && r_i <= r_cnt) ? 32'd1 : 32'd0;
                t_wd = SW'(node_ones);
                if (r_i == {1'b0, N}) n_st = (r_st == S_C1) ? S_OUT : S_IDLE;
            end
            S_IDLE: if (i_valid) begin
                case (i_cmd.mode)
                    wsst_pkg::OP_CLEAR:  n_st = S_C1;
                    wsst_pkg::OP_SELECT: n_st = S_FRD;
                    default:             n_st = S_LRD;
                endcase
            end
            S_LRD: begin
                l_a = clamp;
                n_st = S_LWAIT;
            end
            S_LWAIT: begin
                l_a = clamp;
                l_we = 1'b1;
                l_wd = newleaf;
                n_st = S_URD;
            end
            S_URD: begin
                t_ra = r_i;
                n_st = (r_i == '0 || r_i > {1'b0, N}) ? S_OUT : S_UWAIT;
            end
            S_UWAIT: n_st = S_UWR;
            S_UWR: begin
                t_we = 1'b1;
                t_wa = r_i;
                t_wd = r_rd + r_delta;
                n_st = S_URD;
            end
            S_FRD: begin
                t_ra = nxt;
                n_st = (r_step == '0) ? S_OUT : S_FWAIT;
            end
            S_FWAIT: begin
                t_ra = nxt;
                n_st = S_FDEC;
            end
            S_FDEC: n_st = S_FRD;
            S_OUT: if (i_res_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_INIT;
            r_i   <= '0;
            r_cnt <= {1'b0, N};
            r_tot <= SW'(SLOT_COUNT);
        end else begin
            r_st <= n_st;
            case (r_st)
                S_INIT, S_C1: begin
                    if (r_i == {1'b0, N}) begin
                        r_i   <= '0;
                        r_tot <= SW'(r_cnt);
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_IDLE: if (i_valid) begin
                    r_cmd <= i_cmd;
                    r_i   <= '0;
                    r_pos <= '0;
                    r_step <= (IDX_W+1)'(TOP);
                    r_want <= SW'(i_cmd.target);
                    r_slot <= '0;
                    r_beyond <= 1'b0;
                    r_cnt <= ({1'b0, i_cmd.position} > {1'b0, N}) ? {1'b0, N} :
                        (IDX_W+1)'(i_cmd.position);
                end
                S_LWAIT: begin
                    r_delta <= SW'(newleaf) - SW'(r_lrd);
                    r_tot   <= r_tot + SW'(newleaf) - SW'(r_lrd);
                    r_i     <= clamp;
                end
                S_UWR: r_i <= r_i + lowb;
                S_FRD: if (r_step == '0) begin
                    r_slot <= (r_pos + 1'b1 > {1'b0, N}) ? {1'b0, N} : r_pos + 1'b1;
                    r_beyond <= (SW'(r_cmd.target) > r_tot);
                end
                S_FDEC: begin
                    if (nxt <= {1'b0, N} && r_rd < r_want) begin
                        r_pos  <= nxt;
                        r_want <= r_want - r_rd;
                    end
                    r_step <= r_step >> 1;
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== rtl/core/wsst_checker.sv =====
// Port checker for weighted_select_sum_tree, with its bind.
// Depends only on the top level's ports.
module wsst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_empty,
    input logic        i_pop,
    input logic [10:0] o_selected_slot,
    input logic [41:0] o_total_weight,
    input logic        o_beyond_total
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_total_weight))
        else $error("result changed while stalled");
    a_beyond_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_beyond_total |-> o_selected_slot != 11'd0)
        else $error("beyond flag without slot");
    a_empty_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && i_pop |=> o_empty)
        else $error("result repeated");
endmodule

bind weighted_select_sum_tree wsst_checker u_chk (.*);
